@@ src/etfp_pkg.sv @@
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, formats and constants of the escape-time fractal pixel core.
// ----------------------------------------------------------------------------
package etfp_pkg;

	localparam int MAX_IMAGE_DIM = 4096;
	localparam int IDX_W = $clog2(MAX_IMAGE_DIM);

	localparam int COL_W = 12;
	localparam int PIX_W = 8;
	localparam int THR_W = 11;
	localparam int LIM_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int CW = 32;
	localparam int ZW = 40;
	localparam int FRAC = 28;

	localparam logic signed [ZW-1:0] Z_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ZW-1:0] Z_MIN = 40'sh80_0000_0000;
	localparam logic signed [CW-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [ZW-1:0] CONST_A = 40'sd244276265;

	localparam logic signed [CW-1:0] X_ORIGIN_RST = -32'sd375809638;
	localparam logic signed [CW-1:0] X_STEP_RST = 32'sd524288;
	localparam logic signed [CW-1:0] Y_ORIGIN_RST = -32'sd295279001;
	localparam logic signed [CW-1:0] Y_STEP_RST = 32'sd629146;
	localparam logic [THR_W-1:0] THRESHOLD_RST = 11'd128;
	localparam logic [LIM_W-1:0] LIMIT_RST = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN = 3'd0,
		REG_X_STEP = 3'd1,
		REG_Y_ORIGIN = 3'd2,
		REG_Y_STEP = 3'd3,
		REG_THRESHOLD = 3'd4,
		REG_LIMIT = 3'd5
	} etfp_reg_t;

	typedef enum logic [2:0] {
		OP_ZR_DR,
		OP_ZI_DI,
		OP_ZR_DI,
		OP_ZI_DR,
		OP_ZR_ZR,
		OP_ZI_ZI
	} etfp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PT_X_MUL,
		S_PT_X_ADD,
		S_PT_Y_MUL,
		S_PT_Y_ADD,
		S_TEST,
		S_DIFF,
		S_MUL_ISSUE,
		S_MUL_WAIT,
		S_COMBINE,
		S_SCALE,
		S_CHECK,
		S_EMIT
	} etfp_state_t;

	typedef enum logic [2:0] {
		MP_IDLE,
		MP_LL,
		MP_HL,
		MP_LH,
		MP_HH,
		MP_ACC,
		MP_DONE
	} etfp_mstate_t;

	typedef struct packed {
		logic capture;
		logic pt_mul;
		logic pt_add;
		logic pt_sel_y;
		logic diff;
		logic mul_start;
		etfp_op_t mul_op;
		logic combine;
		logic scale;
		logic advance;
		logic emit;
	} etfp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic more;
		logic escaped;
		logic out_free;
	} etfp_sts_t;

endpackage

@@ src/etfp_if.sv @@
// ----------------------------------------------------------------------------
// etfp_if
// Valid/ready channels of the fractal pixel core: coordinates, pixels, config.
// ----------------------------------------------------------------------------
interface etfp_in_if;
	import etfp_pkg::*;
	logic valid;
	logic ready;
	logic [COL_W-1:0] column;
	logic [COL_W-1:0] row;
	modport source (output valid, output column, output row, input ready);
	modport sink (input valid, input column, input row, output ready);
endinterface

interface etfp_out_if;
	import etfp_pkg::*;
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel_value;
	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface etfp_cfg_if;
	import etfp_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/etfp_qmul.sv @@
// ----------------------------------------------------------------------------
// etfp_qmul
// Iterative Q11.28 multiplier: one 28x28 partial product per cycle, rounded
// half away from zero, saturated to the Q11.28 range.
// ----------------------------------------------------------------------------
module etfp_qmul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [etfp_pkg::ZW-1:0] a,
	input  logic signed [etfp_pkg::ZW-1:0] b,
	output logic                          done,
	output logic signed [etfp_pkg::ZW-1:0] p
);
	import etfp_pkg::*;

	etfp_mstate_t mst_q, mst_d;
	logic neg_q;
	logic [ZW-1:0] ua_q, ub_q;
	logic [2*FRAC-1:0] prod_s1;
	logic [ZW+1:0] acc_q;
	logic sat_q;
	logic signed [ZW-1:0] p_q;
	logic done_q;

	logic [FRAC-1:0] mx, my;
	logic [2*FRAC-1:0] rnd;
	logic [ZW-1:0] mag;

	always_comb begin
		mst_d = mst_q;
		unique case (mst_q)
			MP_IDLE: if (start) mst_d = MP_LL;
			MP_LL:   mst_d = MP_HL;
			MP_HL:   mst_d = MP_LH;
			MP_LH:   mst_d = MP_HH;
			MP_HH:   mst_d = MP_ACC;
			MP_ACC:  mst_d = MP_DONE;
			MP_DONE: mst_d = MP_IDLE;
			default: mst_d = MP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q <= MP_IDLE;
			done_q <= 1'b0;
		end else begin
			mst_q <= mst_d;
			done_q <= (mst_q == MP_DONE);
		end
	end

	always_comb begin
		mx = (mst_q == MP_HL || mst_q == MP_HH) ? FRAC'(ua_q[ZW-1:FRAC]) : ua_q[FRAC-1:0];
		my = (mst_q == MP_LH || mst_q == MP_HH) ? FRAC'(ub_q[ZW-1:FRAC]) : ub_q[FRAC-1:0];
		rnd = prod_s1 + {1'b1, (FRAC-1)'(0)};
		mag = (sat_q || acc_q > (ZW+2)'(Z_MAX)) ? Z_MAX : acc_q[ZW-1:0];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mx * my;
		if (mst_q == MP_IDLE && start) begin
			neg_q <= a[ZW-1] ^ b[ZW-1];
			ua_q <= a[ZW-1] ? (~a + 1'b1) : a;
			ub_q <= b[ZW-1] ? (~b + 1'b1) : b;
		end
		unique case (mst_q)
			MP_HL: acc_q <= (ZW+2)'(rnd >> FRAC);
			MP_LH, MP_HH: acc_q <= acc_q + (ZW+2)'(prod_s1);
			MP_ACC: begin
				sat_q <= |prod_s1[2*FRAC-1:ZW-FRAC];
				acc_q <= acc_q + (ZW+2)'({prod_s1[ZW-FRAC-1:0], FRAC'(0)});
			end
			MP_DONE: p_q <= neg_q ? -$signed(mag) : $signed(mag);
			default: ;
		endcase
	end

	assign done = done_q;
	assign p = p_q;

endmodule

@@ src/etfp_datapath.sv @@
// ----------------------------------------------------------------------------
// etfp_datapath
// Configuration registers, point mapping, complex orbit registers, escape
// test, step counter and output register of the fractal pixel core.
// ----------------------------------------------------------------------------
module etfp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  etfp_pkg::etfp_cmd_t             cmd,
	output etfp_pkg::etfp_sts_t             sts,
	input  logic [etfp_pkg::COL_W-1:0]      column,
	input  logic [etfp_pkg::COL_W-1:0]      row,
	etfp_cfg_if.sink                        cfg,
	etfp_out_if.source                      pixel
);
	import etfp_pkg::*;

	localparam int PT_W = IDX_W + CW + 2;

	function automatic logic signed [ZW-1:0] sat_z(input logic signed [ZW+3:0] v);
		if (v > Z_MAX) return Z_MAX;
		else if (v < Z_MIN) return Z_MIN;
		else return v[ZW-1:0];
	endfunction

	logic signed [CW-1:0] x_origin_q, x_step_q, y_origin_q, y_step_q;
	logic [THR_W-1:0] thr_q;
	logic [LIM_W-1:0] lim_q;

	logic [COL_W-1:0] col_q, row_q;
	logic signed [PT_W-1:0] pt_prod_q;
	logic signed [ZW-1:0] zr_q, zi_q, dr_q, di_q;
	logic signed [ZW-1:0] pa_q, pb_q, pc_q, pd_q, sr_q, si_q, mr_q, mi_q;
	etfp_op_t mul_op_q;
	logic [LIM_W-1:0] i_q;
	logic [PIX_W-1:0] pix_q;
	logic out_valid_q;

	logic [IDX_W:0] pt_k;
	logic signed [CW-1:0] pt_step, pt_origin, pt_c;
	logic signed [PT_W-1:0] pt_prod, pt_half;
	logic signed [PT_W:0] pt_sum;
	logic signed [ZW-1:0] mul_a, mul_b, mul_p;
	logic mul_done;
	logic signed [ZW:0] mag2, bound;
	logic [LIM_W-1:0] cnt_min;
	logic [LIM_W:0] cnt_dbl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= X_ORIGIN_RST;
			x_step_q <= X_STEP_RST;
			y_origin_q <= Y_ORIGIN_RST;
			y_step_q <= Y_STEP_RST;
			thr_q <= THRESHOLD_RST;
			lim_q <= LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (etfp_reg_t'(cfg.index))
				REG_X_ORIGIN:  x_origin_q <= cfg.data[CW-1:0];
				REG_X_STEP:    x_step_q <= cfg.data[CW-1:0];
				REG_Y_ORIGIN:  y_origin_q <= cfg.data[CW-1:0];
				REG_Y_STEP:    y_step_q <= cfg.data[CW-1:0];
				REG_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				REG_LIMIT:     lim_q <= cfg.data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pt_k = {cmd.pt_sel_y ? row_q[IDX_W-1:0] : col_q[IDX_W-1:0], 1'b1};
		pt_step = cmd.pt_sel_y ? y_step_q : x_step_q;
		pt_origin = cmd.pt_sel_y ? y_origin_q : x_origin_q;
		pt_prod = $signed({1'b0, pt_k}) * pt_step;
		pt_half = pt_prod_q >>> 1;
		pt_sum = (PT_W+1)'(pt_origin) + (PT_W+1)'(pt_half);
		if (pt_sum > C_MAX) pt_c = C_MAX;
		else if (pt_sum < C_MIN) pt_c = C_MIN;
		else pt_c = pt_sum[CW-1:0];
	end

	always_comb begin
		unique case (cmd.mul_op)
			OP_ZR_DR: begin mul_a = zr_q; mul_b = dr_q; end
			OP_ZI_DI: begin mul_a = zi_q; mul_b = di_q; end
			OP_ZR_DI: begin mul_a = zr_q; mul_b = di_q; end
			OP_ZI_DR: begin mul_a = zi_q; mul_b = dr_q; end
			OP_ZR_ZR: begin mul_a = zr_q; mul_b = zr_q; end
			OP_ZI_ZI: begin mul_a = zi_q; mul_b = zi_q; end
			default:  begin mul_a = zr_q; mul_b = zr_q; end
		endcase
	end

	etfp_qmul u_qmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		mag2 = (ZW+1)'(sr_q) + (ZW+1)'(si_q);
		bound = $signed({(ZW+1-THR_W-FRAC)'(0), thr_q, FRAC'(0)});
		cnt_min = (i_q < lim_q) ? i_q : lim_q;
		cnt_dbl = {cnt_min, 1'b0};
		sts.mul_done = mul_done;
		sts.more = i_q < lim_q;
		sts.escaped = mag2 > bound;
		sts.out_free = !out_valid_q || pixel.ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= column;
			row_q <= row;
			i_q <= LIM_W'(1);
		end
		if (cmd.advance) i_q <= i_q + LIM_W'(2);
		if (cmd.pt_mul) pt_prod_q <= pt_prod;
		if (cmd.pt_add) begin
			if (cmd.pt_sel_y) zi_q <= ZW'(pt_c);
			else zr_q <= ZW'(pt_c);
		end
		if (cmd.diff) begin
			dr_q <= sat_z((ZW+4)'(CONST_A) - (ZW+4)'(zr_q));
			di_q <= sat_z(-(ZW+4)'(zi_q));
		end
		if (cmd.mul_start) mul_op_q <= cmd.mul_op;
		if (mul_done) begin
			unique case (mul_op_q)
				OP_ZR_DR: pa_q <= mul_p;
				OP_ZI_DI: pb_q <= mul_p;
				OP_ZR_DI: pc_q <= mul_p;
				OP_ZI_DR: pd_q <= mul_p;
				OP_ZR_ZR: sr_q <= mul_p;
				OP_ZI_ZI: si_q <= mul_p;
				default: ;
			endcase
		end
		if (cmd.combine) begin
			mr_q <= sat_z((ZW+4)'(pa_q) - (ZW+4)'(pb_q));
			mi_q <= sat_z((ZW+4)'(pc_q) + (ZW+4)'(pd_q));
		end
		if (cmd.scale) begin
			zr_q <= sat_z((ZW+4)'(mr_q) <<< 2);
			zi_q <= sat_z((ZW+4)'(mi_q) <<< 2);
		end
		if (cmd.emit) pix_q <= cnt_dbl[LIM_W] ? {PIX_W{1'b1}} : PIX_W'(cnt_dbl[LIM_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (pixel.ready) out_valid_q <= 1'b0;
	end

	assign pixel.valid = out_valid_q;
	assign pixel.pixel_value = pix_q;

endmodule

@@ src/etfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer of the fractal pixel core: point mapping, orbit steps through the
// shared multiplier, escape test and pixel hand-off.
// ----------------------------------------------------------------------------
module etfp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  etfp_pkg::etfp_sts_t sts,
	output etfp_pkg::etfp_cmd_t cmd
);
	import etfp_pkg::*;

	etfp_state_t state_q, state_d;
	etfp_op_t op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ZR_DR;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		cmd = '0;
		cmd.mul_op = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_PT_X_MUL;
				end
			end
			S_PT_X_MUL: begin
				cmd.pt_mul = 1'b1;
				state_d = S_PT_X_ADD;
			end
			S_PT_X_ADD: begin
				cmd.pt_add = 1'b1;
				state_d = S_PT_Y_MUL;
			end
			S_PT_Y_MUL: begin
				cmd.pt_mul = 1'b1;
				cmd.pt_sel_y = 1'b1;
				state_d = S_PT_Y_ADD;
			end
			S_PT_Y_ADD: begin
				cmd.pt_add = 1'b1;
				cmd.pt_sel_y = 1'b1;
				state_d = S_TEST;
			end
			S_TEST: state_d = sts.more ? S_DIFF : S_EMIT;
			S_DIFF: begin
				cmd.diff = 1'b1;
				op_d = OP_ZR_DR;
				state_d = S_MUL_ISSUE;
			end
			S_MUL_ISSUE: begin
				cmd.mul_start = 1'b1;
				state_d = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					unique case (op_q)
						OP_ZR_DR: begin op_d = OP_ZI_DI; state_d = S_MUL_ISSUE; end
						OP_ZI_DI: begin op_d = OP_ZR_DI; state_d = S_MUL_ISSUE; end
						OP_ZR_DI: begin op_d = OP_ZI_DR; state_d = S_MUL_ISSUE; end
						OP_ZI_DR: state_d = S_COMBINE;
						OP_ZR_ZR: begin op_d = OP_ZI_ZI; state_d = S_MUL_ISSUE; end
						OP_ZI_ZI: state_d = S_CHECK;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_COMBINE: begin
				cmd.combine = 1'b1;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				op_d = OP_ZR_ZR;
				state_d = S_MUL_ISSUE;
			end
			S_CHECK: begin
				if (sts.escaped) begin
					state_d = S_EMIT;
				end else begin
					cmd.advance = 1'b1;
					state_d = S_TEST;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ src/escape_time_fractal_pixel_core.sv @@
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_core
// Escape-time pixel generator for the complex logistic map z = 4z(0.91 - z).
//
//   channel  dir  payload              beat
//   coord    in   column, row          one pixel request
//   pixel    out  pixel_value          one grey level
//   cfg      in   index, data          one register write
//
// A pixel takes up to 127 orbit steps: each step runs six Q11.28 products through
// one shared 28x28 multiplier, four partial products per product.
// Reset clears the sequencer and the output valid flag and reloads the config.
// A new coord beat is taken while a finished pixel still waits on the output;
// the next pixel waits before hand-off until that one is taken.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_core (
	input  logic        clk,
	input  logic        arst_n,
	etfp_cfg_if.sink    cfg,
	etfp_in_if.sink     coord,
	etfp_out_if.source  pixel
);
	import etfp_pkg::*;

	etfp_cmd_t cmd;
	etfp_sts_t sts;
	logic in_ready;

	etfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (coord.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign coord.ready = in_ready;

	etfp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.column (coord.column),
		.row    (coord.row),
		.cfg    (cfg),
		.pixel  (pixel)
	);

endmodule

@@ src/etfp_checker.sv @@
// ----------------------------------------------------------------------------
// etfp_checker
// Port-level checks of the fractal pixel core, bound to the top level.
// ----------------------------------------------------------------------------
module etfp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       coord_valid,
	input logic                       coord_ready,
	input logic                       pixel_valid,
	input logic                       pixel_ready,
	input logic [etfp_pkg::PIX_W-1:0] pixel_value
);
	import etfp_pkg::*;

	logic coord_beat;
	assign coord_beat = coord_valid && coord_ready;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		coord_beat |=> !coord_ready)
		else $error("coord taken while a pixel is in progress");

	a_no_early_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		coord_beat |=> !$rose(pixel_valid) ##1 !$rose(pixel_valid))
		else $error("pixel beat appeared too soon after coord beat");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid)
		else $error("pixel valid dropped while stalled");

	a_value_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> $stable(pixel_value))
		else $error("pixel value changed while stalled");

endmodule

bind escape_time_fractal_pixel_core etfp_checker u_etfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.coord_valid (coord.valid),
	.coord_ready (coord.ready),
	.pixel_valid (pixel.valid),
	.pixel_ready (pixel.ready),
	.pixel_value (pixel.pixel_value)
);
